[design/soa_pkg.sv]
// slab object allocator shared constants
// op, status and class codes, minimum object size and address width; no dependencies
package soa_pkg;
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOSLOT = 2'd1;
  localparam logic [1:0] ST_BADADR = 2'd2;
  localparam logic [1:0] CLS_NONE    = 2'd0;
  localparam logic [1:0] CLS_EMPTY   = 2'd1;
  localparam logic [1:0] CLS_PARTIAL = 2'd2;
  localparam logic [1:0] CLS_FULL    = 2'd3;
  localparam int MIN_OBJECT = 16;
  localparam int ADDR_W = 15;
endpackage

[design/slab_object_allocator_top.sv]
// slab object allocator top level
// one sequencer around a shared add/compare unit and a slot bitmap ram
// depends on soa_pkg and soa_ram
//
// in channel: in_tdata = {free_address, op}; in_tready is high only in idle
// with no result waiting and no cfg write
// out channel: out_tdata = {status, object_address}, held in an output register
// alloc: scans the slab records one per cycle, picks or creates a slab, then
// probes the bitmap one bit at a time, a read state then a check state per bit, up to the first clear slot; the
// slot address is built by repeated addition of the object size
// free: scans slabs one per cycle, then divides by repeated subtraction
// one request at a time: in_tready returns the cycle after the result beat leaves
// reset and a cfg write clear all slabs through a pass over every bitmap ram entry
// (2048 entries with the defaults), then recount the slots per slab; no request
// is accepted during it
// a stalled out_tready holds the result and keeps in_tready low
module slab_object_allocator_top #(
  parameter int MAX_SLABS    = 8,
  parameter int SLAB_BYTES   = 4096,
  parameter int HEADER_BYTES = 48,
  parameter int SLOT_BITS    = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // op, free_address
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // object_address, status, zero fill
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata
);
  localparam int SW = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
  localparam int IW = $clog2(SLOT_BITS);
  localparam int CW = $clog2(SLOT_BITS + 1);
  localparam int RD = MAX_SLABS * (1 << IW);
  localparam int RW = $clog2(RD);
  localparam int NW = $clog2(MAX_SLABS + 1);
  localparam int AW = 32;
  localparam logic [CW-1:0] SPS16 =
    CW'(((SLAB_BYTES - HEADER_BYTES) / 16 > SLOT_BITS) ? SLOT_BITS
        : (SLAB_BYTES - HEADER_BYTES) / 16);

  localparam logic [3:0] S_CLR = 4'd0, S_SPS = 4'd1, S_IDLE = 4'd2, S_PICK = 4'd3,
    S_SRCH = 4'd4, S_SRD = 4'd5, S_ADDR = 4'd6, S_FIND = 4'd7, S_DIV = 4'd8,
    S_FRD = 4'd9, S_FCHK = 4'd10, S_OUT = 4'd11;

  logic [3:0]       st_r;
  logic [11:0]      size_r;
  logic [CW-1:0]    sps_r;
  logic [31:0]      acc_r;
  logic [CW-1:0]    cnt_r;
  logic [SW-1:0]    k_r;
  logic [NW-1:0]    scan_r;
  logic             fnd_r, pfnd_r;
  logic [15:0]      bage_r;
  logic [1:0]       cls_r [MAX_SLABS];
  logic [CW-1:0]    used_r [MAX_SLABS];
  logic [15:0]      stamp_r [MAX_SLABS];
  logic [15:0]      ctr_r;
  logic [NW-1:0]    made_r;
  logic [14:0]      fadr_r;
  logic [RW-1:0]    clr_r;
  logic             out_v_r;
  logic [14:0]      oadr_r;
  logic [1:0]       ost_r;

  logic [11:0] esize;
  assign esize = (size_r < 12'(soa_pkg::MIN_OBJECT)) ? 12'(soa_pkg::MIN_OBJECT) : size_r;

  logic          we, wd, rdq;
  logic [RW-1:0] wa, ra;
  soa_ram #(.WIDTH(1), .DEPTH(RD)) u_ram (
    .clk(clk), .we(we), .waddr(wa), .wdata(wd), .raddr(ra), .rdata(rdq)
  );

  logic [IW-1:0] slot;
  assign slot = cnt_r[IW-1:0];
  assign ra = RW'({k_r, slot});

  logic [SW-1:0] kk;
  assign kk = scan_r[SW-1:0];
  logic [15:0] age;
  assign age = ctr_r - stamp_r[kk];

  logic [AW-1:0] lo, hi;
  assign lo = AW'(kk) * AW'(SLAB_BYTES) + AW'(HEADER_BYTES);
  assign hi = AW'(kk) * AW'(SLAB_BYTES) + AW'(SLAB_BYTES);

  assign in_tready = (st_r == S_IDLE) && !out_v_r && !cfg_we;
  assign out_tvalid = out_v_r;
  assign out_tdata = {7'd0, ost_r, oadr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; size_r <= 12'd16; sps_r <= SPS16;
      out_v_r <= 1'b0; ctr_r <= '0; made_r <= '0;
      for (int i = 0; i < MAX_SLABS; i++) begin
        cls_r[i] <= soa_pkg::CLS_NONE; used_r[i] <= '0; stamp_r[i] <= '0;
      end
    end else if (cfg_we) begin
      size_r <= cfg_wdata; st_r <= S_CLR; clr_r <= '0;
      ctr_r <= '0; made_r <= '0;
      for (int i = 0; i < MAX_SLABS; i++) begin
        cls_r[i] <= soa_pkg::CLS_NONE; used_r[i] <= '0; stamp_r[i] <= '0;
      end
    end else begin
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == RW'(RD - 1)) begin
            st_r <= S_SPS; acc_r <= SLAB_BYTES - HEADER_BYTES; cnt_r <= '0;
          end
        end
        S_SPS: begin
          if (acc_r >= 32'(esize) && cnt_r != CW'(SLOT_BITS)) begin
            acc_r <= acc_r - 32'(esize); cnt_r <= cnt_r + 1'b1;
          end else begin
            sps_r <= cnt_r; st_r <= S_IDLE;
          end
        end
        S_IDLE: if (in_tvalid && !out_v_r) begin
          fadr_r <= in_tdata[15:1];
          scan_r <= '0; fnd_r <= 1'b0; pfnd_r <= 1'b0;
          st_r <= in_tdata[0] ? S_FIND : S_PICK;
          if (!in_tdata[0] && sps_r == '0) begin
            ost_r <= soa_pkg::ST_NOSLOT; oadr_r <= '0; st_r <= S_OUT;
          end
        end
        S_PICK: begin
          if (scan_r != NW'(MAX_SLABS)) begin
            if (cls_r[kk] == soa_pkg::CLS_PARTIAL) begin
              if (!pfnd_r || age < bage_r) begin
                k_r <= kk; bage_r <= age; pfnd_r <= 1'b1;
              end
            end else if (cls_r[kk] == soa_pkg::CLS_EMPTY && !pfnd_r) begin
              if (!fnd_r || age < bage_r) begin
                k_r <= kk; bage_r <= age; fnd_r <= 1'b1;
              end
            end
            scan_r <= scan_r + 1'b1;
          end else if (pfnd_r || fnd_r) begin
            cnt_r <= '0; st_r <= S_SRD;
          end else if (made_r == NW'(MAX_SLABS)) begin
            ost_r <= soa_pkg::ST_NOSLOT; oadr_r <= '0; st_r <= S_OUT;
          end else begin
            k_r <= made_r[SW-1:0]; made_r <= made_r + 1'b1;
            cls_r[made_r[SW-1:0]] <= soa_pkg::CLS_PARTIAL;
            used_r[made_r[SW-1:0]] <= '0;
            stamp_r[made_r[SW-1:0]] <= ctr_r; ctr_r <= ctr_r + 1'b1;
            cnt_r <= '0; st_r <= S_SRD;
          end
        end
        S_SRD: st_r <= S_SRCH;
        S_SRCH: begin
          if (cnt_r >= sps_r) begin
            ost_r <= soa_pkg::ST_NOSLOT; oadr_r <= '0; st_r <= S_OUT;
          end else if (!rdq) begin
            used_r[k_r] <= used_r[k_r] + 1'b1;
            if (used_r[k_r] + 1'b1 >= sps_r) begin
              cls_r[k_r] <= soa_pkg::CLS_FULL; stamp_r[k_r] <= ctr_r;
              ctr_r <= ctr_r + 1'b1;
            end else if (used_r[k_r] == '0) begin
              cls_r[k_r] <= soa_pkg::CLS_PARTIAL; stamp_r[k_r] <= ctr_r;
              ctr_r <= ctr_r + 1'b1;
            end
            acc_r <= 32'(k_r) * SLAB_BYTES + HEADER_BYTES;
            st_r <= S_ADDR;
          end else begin
            cnt_r <= cnt_r + 1'b1; st_r <= S_SRD;
          end
        end
        S_ADDR: begin
          if (cnt_r != '0) begin
            acc_r <= acc_r + 32'(esize); cnt_r <= cnt_r - 1'b1;
          end else begin
            ost_r <= soa_pkg::ST_OK; oadr_r <= acc_r[14:0]; st_r <= S_OUT;
          end
        end
        S_FIND: begin
          if (scan_r == NW'(MAX_SLABS)) begin
            ost_r <= soa_pkg::ST_BADADR; oadr_r <= '0; st_r <= S_OUT;
          end else if ((cls_r[kk] == soa_pkg::CLS_PARTIAL || cls_r[kk] == soa_pkg::CLS_FULL)
                       && AW'(fadr_r) >= lo && AW'(fadr_r) < hi) begin
            k_r <= kk; acc_r <= AW'(fadr_r) - lo; cnt_r <= '0; st_r <= S_DIV;
          end else scan_r <= scan_r + 1'b1;
        end
        S_DIV: begin
          if (acc_r >= 32'(esize) && cnt_r != CW'(SLOT_BITS)) begin
            acc_r <= acc_r - 32'(esize); cnt_r <= cnt_r + 1'b1;
          end else if (cnt_r >= sps_r) begin
            ost_r <= soa_pkg::ST_BADADR; oadr_r <= '0; st_r <= S_OUT;
          end else st_r <= S_FRD;
        end
        S_FRD: st_r <= S_FCHK;
        S_FCHK: begin
          oadr_r <= '0;
          if (!rdq) ost_r <= soa_pkg::ST_BADADR;
          else begin
            ost_r <= soa_pkg::ST_OK;
            used_r[k_r] <= used_r[k_r] - 1'b1;
            if (used_r[k_r] == CW'(1)) begin
              cls_r[k_r] <= soa_pkg::CLS_EMPTY; stamp_r[k_r] <= ctr_r;
              ctr_r <= ctr_r + 1'b1;
            end else if (used_r[k_r] == sps_r) begin
              cls_r[k_r] <= soa_pkg::CLS_PARTIAL; stamp_r[k_r] <= ctr_r;
              ctr_r <= ctr_r + 1'b1;
            end
          end
          st_r <= S_OUT;
        end
        S_OUT: begin
          out_v_r <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    we = 1'b0; wa = ra; wd = 1'b0;
    if (st_r == S_CLR) begin
      we = 1'b1; wa = clr_r;
    end else if (st_r == S_SRCH && !cfg_we && cnt_r < sps_r && !rdq) begin
      we = 1'b1; wd = 1'b1;
    end else if (st_r == S_FCHK && !cfg_we && rdq) begin
      we = 1'b1;
    end
  end

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_tready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready) |=> out_v_r) else $error("result dropped");
  a_made: assert property (@(posedge clk) disable iff (!rst_n)
    made_r <= NW'(MAX_SLABS)) else $error("slab count overflow");
endmodule

[design/soa_ram.sv]
// generic single write, single read ram with registered read
// no dependencies
module soa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
